[design/sbcl_pkg.sv]
// ----------------------------------------------------------------------------
// sbcl_pkg - shared types and constants for the single-button code lock
// Holds the configuration and result structs, phase codes, register
// indexes and reset values used across the lock's modules.
// ----------------------------------------------------------------------------
package sbcl_pkg;

    // default sizing
    localparam int DIGIT_COUNT_DEF = 3;
    localparam int DIGIT_BITS_DEF  = 4;
    localparam int TIMER_BITS_DEF  = 16;

    // fixed field widths
    localparam int CODE_BITS   = 12;
    localparam int LIMIT_BITS  = 4;
    localparam int TICK_BITS   = 16;
    localparam int PRESS_BITS  = 4;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = 16;
    localparam int IN_TDATA_BITS = 8;
    localparam int OUT_TDATA_BITS = 16;

    // saturation point of the press counter
    localparam logic [PRESS_BITS-1:0] PRESS_MAX = 4'd15;

    // register reset values
    localparam logic [CODE_BITS-1:0]  CODE_WORD_RST  = 12'd801;
    localparam logic [LIMIT_BITS-1:0] PRESS_LIMIT_RST = 4'd10;
    localparam logic [TICK_BITS-1:0]  DEBOUNCE_RST   = 16'd50;
    localparam logic [TICK_BITS-1:0]  TIMEOUT_RST    = 16'd1000;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_CODE_WORD   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PRESS_LIMIT = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DEBOUNCE    = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TIMEOUT     = 2'd3;

    // lock phase codes
    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_COUNT  = 2'd1;
    localparam logic [1:0] PH_STORED = 2'd2;

    typedef struct packed {
        logic [TICK_BITS-1:0]  digit_timeout_ticks;
        logic [TICK_BITS-1:0]  debounce_ticks;
        logic [LIMIT_BITS-1:0] press_limit;
        logic [CODE_BITS-1:0]  code_word;
    } cfg_t;

    typedef struct packed {
        logic                  code_matches;
        logic                  verdict_valid;
        logic                  digit_done;
        logic [PRESS_BITS-1:0] press_total;
        logic [1:0]            digits_entered;
        logic [1:0]            lock_phase;
    } result_t;

endpackage

[design/sbcl_cfg_regs.sv]
// ----------------------------------------------------------------------------
// sbcl_cfg_regs - configuration register file
// Takes register writes by index and presents all settings as one struct.
// ----------------------------------------------------------------------------
module sbcl_cfg_regs
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sbcl_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [sbcl_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output sbcl_pkg::cfg_t                      cfg
);

    sbcl_pkg::cfg_t cfg_reg;
    sbcl_pkg::cfg_t cfg_next;

    // always take writes
    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    // decode the write into the addressed field
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                sbcl_pkg::CFG_CODE_WORD:
                    cfg_next.code_word = cfg_data[sbcl_pkg::CODE_BITS-1:0];
                sbcl_pkg::CFG_PRESS_LIMIT:
                    cfg_next.press_limit = cfg_data[sbcl_pkg::LIMIT_BITS-1:0];
                sbcl_pkg::CFG_DEBOUNCE:
                    cfg_next.debounce_ticks = cfg_data;
                sbcl_pkg::CFG_TIMEOUT:
                    cfg_next.digit_timeout_ticks = cfg_data;
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.code_word           <= sbcl_pkg::CODE_WORD_RST;
            cfg_reg.press_limit         <= sbcl_pkg::PRESS_LIMIT_RST;
            cfg_reg.debounce_ticks      <= sbcl_pkg::DEBOUNCE_RST;
            cfg_reg.digit_timeout_ticks <= sbcl_pkg::TIMEOUT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[design/sbcl_in_stage.sv]
// ----------------------------------------------------------------------------
// sbcl_in_stage - input register
// Holds one tick item and hands it to the lock core when the result
// register can take the outcome.
// ----------------------------------------------------------------------------
module sbcl_in_stage
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [sbcl_pkg::IN_TDATA_BITS-1:0]   s_tdata,
    input  logic                                 out_free,
    output logic                                 step,
    output logic                                 key_event
);

    logic valid_reg;
    logic valid_next;
    logic key_reg;

    // advance the held item whenever the result side has room
    assign step      = valid_reg && out_free;
    assign s_tready  = !valid_reg || out_free;
    assign key_event = key_reg;

    assign valid_next = (s_tvalid && s_tready) ? 1'b1 : (step ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // capture the key flag of an accepted item
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            key_reg <= s_tdata[0];
        end
    end

endmodule

[design/sbcl_core.sv]
// ----------------------------------------------------------------------------
// sbcl_core - lock state and single-tick update
// Runs the timers, debounce, digit collection and code check for one
// tick item per step and presents that tick's result.
// ----------------------------------------------------------------------------
module sbcl_core
#(
    parameter int DIGIT_COUNT = sbcl_pkg::DIGIT_COUNT_DEF,
    parameter int DIGIT_BITS  = sbcl_pkg::DIGIT_BITS_DEF,
    parameter int TIMER_BITS  = sbcl_pkg::TIMER_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic              key_event,
    input  sbcl_pkg::cfg_t    cfg,
    output sbcl_pkg::result_t result
);

    localparam int POS_BITS = $clog2(DIGIT_COUNT + 1);
    localparam logic [POS_BITS-1:0] POS_FULL = POS_BITS'(DIGIT_COUNT);

    logic [1:0]                      phase_reg;
    logic [1:0]                      phase_next;
    logic                            pending_reg;
    logic                            pending_next;
    logic [sbcl_pkg::PRESS_BITS-1:0] count_reg;
    logic [sbcl_pkg::PRESS_BITS-1:0] count_next;
    logic [POS_BITS-1:0]             pos_reg;
    logic [POS_BITS-1:0]             pos_next;
    logic [DIGIT_BITS-1:0]           digit_reg  [DIGIT_COUNT];
    logic [DIGIT_BITS-1:0]           digit_next [DIGIT_COUNT];
    logic [TIMER_BITS-1:0]           tmo_reg;
    logic [TIMER_BITS-1:0]           tmo_next;
    logic [TIMER_BITS-1:0]           deb_reg;
    logic [TIMER_BITS-1:0]           deb_next;

    logic [TIMER_BITS-1:0]           tmo_dec;
    logic [TIMER_BITS-1:0]           deb_dec;
    logic                            pending_a;
    logic                            digits_left;
    logic                            do_press;
    logic                            do_store;
    logic                            do_check;
    logic                            codes_equal;
    logic [DIGIT_BITS-1:0]           store_val;
    logic [DIGIT_BITS-1:0]           want;
    logic [TIMER_BITS-1:0]           tmo_load;
    logic [TIMER_BITS-1:0]           deb_load;
    logic [sbcl_pkg::PRESS_BITS-1:0] count_inc;

    assign tmo_load = TIMER_BITS'(cfg.digit_timeout_ticks);
    assign deb_load = TIMER_BITS'(cfg.debounce_ticks);

    // count the timers down, then debounce the raw press
    assign tmo_dec   = (tmo_reg != '0) ? tmo_reg - 1'b1 : tmo_reg;
    assign deb_dec   = (deb_reg != '0) ? deb_reg - 1'b1 : deb_reg;
    assign pending_a = pending_reg || (key_event && (deb_dec == '0));

    assign digits_left = pos_reg < POS_FULL;
    assign count_inc   = (count_reg < sbcl_pkg::PRESS_MAX) ? count_reg + 1'b1 : count_reg;
    assign store_val   = (count_reg < cfg.press_limit) ? DIGIT_BITS'(count_reg) : '0;

    // pick the one phase transition for this tick
    always_comb
    begin
        do_press = 1'b0;
        do_store = 1'b0;
        do_check = 1'b0;
        case (phase_reg)
            sbcl_pkg::PH_COUNT:
            begin
                if (pending_a && digits_left)
                    do_press = 1'b1;
                else if (count_reg >= cfg.press_limit || tmo_dec == '0)
                    do_store = 1'b1;
            end
            sbcl_pkg::PH_STORED:
            begin
                if (pending_a && digits_left)
                    do_press = 1'b1;
                else if (!digits_left)
                    do_check = 1'b1;
            end
            default:
            begin
                if (pending_a && digits_left)
                    do_press = 1'b1;
            end
        endcase
    end

    // compare stored digits against the code word, digit by digit
    always_comb
    begin
        codes_equal = 1'b1;
        want        = '0;
        for (int i = 0; i < DIGIT_COUNT; i++)
        begin
            for (int b = 0; b < DIGIT_BITS; b++)
            begin
                if (i * DIGIT_BITS + b < sbcl_pkg::CODE_BITS)
                    want[b] = cfg.code_word[i * DIGIT_BITS + b];
                else
                    want[b] = 1'b0;
            end
            if (digit_reg[i] != want)
                codes_equal = 1'b0;
        end
    end

    // next state
    always_comb
    begin
        phase_next   = phase_reg;
        pending_next = pending_a;
        count_next   = count_reg;
        pos_next     = pos_reg;
        tmo_next     = tmo_dec;
        deb_next     = key_event ? deb_load : deb_dec;
        for (int i = 0; i < DIGIT_COUNT; i++)
            digit_next[i] = digit_reg[i];

        if (do_press)
        begin
            pending_next = 1'b0;
            count_next   = count_inc;
            tmo_next     = tmo_load;
            phase_next   = sbcl_pkg::PH_COUNT;
        end
        else if (do_store)
        begin
            pending_next = 1'b0;
            for (int i = 0; i < DIGIT_COUNT; i++)
            begin
                if (pos_reg == POS_BITS'(i))
                    digit_next[i] = store_val;
            end
            count_next = '0;
            if (digits_left)
                pos_next = pos_reg + 1'b1;
            phase_next = sbcl_pkg::PH_STORED;
        end
        else if (do_check)
        begin
            pending_next = 1'b0;
            for (int i = 0; i < DIGIT_COUNT; i++)
                digit_next[i] = '0;
            pos_next   = '0;
            phase_next = sbcl_pkg::PH_IDLE;
        end
    end

    // result of this tick
    always_comb
    begin
        result.lock_phase     = phase_next;
        result.digits_entered = 2'(pos_next);
        result.press_total    = count_next;
        result.digit_done     = do_store;
        result.verdict_valid  = do_check;
        result.code_matches   = do_check && codes_equal;
    end

    // commit state on each stepped item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= sbcl_pkg::PH_IDLE;
            pending_reg <= 1'b0;
            count_reg   <= '0;
            pos_reg     <= '0;
            tmo_reg     <= '0;
            deb_reg     <= TIMER_BITS'(sbcl_pkg::DEBOUNCE_RST);
            for (int i = 0; i < DIGIT_COUNT; i++)
                digit_reg[i] <= '0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            pending_reg <= pending_next;
            count_reg   <= count_next;
            pos_reg     <= pos_next;
            tmo_reg     <= tmo_next;
            deb_reg     <= deb_next;
            for (int i = 0; i < DIGIT_COUNT; i++)
                digit_reg[i] <= digit_next[i];
        end
    end

endmodule

[design/sbcl_out_stage.sv]
// ----------------------------------------------------------------------------
// sbcl_out_stage - result register
// Holds one result item until the downstream side takes it.
// ----------------------------------------------------------------------------
module sbcl_out_stage
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 step,
    input  sbcl_pkg::result_t                    result,
    output logic                                 out_free,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [sbcl_pkg::OUT_TDATA_BITS-1:0]  m_tdata
);

    logic              valid_reg;
    logic              valid_next;
    sbcl_pkg::result_t data_reg;

    // room when empty or being drained this cycle
    assign out_free   = !valid_reg || m_tready;
    assign valid_next = step ? 1'b1 : (m_tready ? 1'b0 : valid_reg);
    assign m_tvalid   = valid_reg;
    assign m_tdata    = sbcl_pkg::OUT_TDATA_BITS'(data_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // load a new result item
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            data_reg <= result;
        end
    end

endmodule

[design/single_button_code_lock.sv]
// ----------------------------------------------------------------------------
// single_button_code_lock - code lock entered with one key
// Debounces key presses per tick, turns press counts into digits and
// checks the finished code against the configured code word.
//
//   channel   dir  handshake            payload
//   s_*       in   s_tvalid/s_tready    s_tdata: key_event
//   m_*       out  m_tvalid/m_tready    m_tdata: phase, digits, presses, flags
//   cfg_*     in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One tick item per clock while the result side drains; each item is held
// in the input register and its result is loaded into the result register.
// The whole tick update is one pass of compares and counter updates.
// Reset is asynchronous, active low; valid flags, configuration and lock state
// take their reset values at once, the key flag and result data are not reset.
// A stalled result register holds the input side after one buffered item.
// ----------------------------------------------------------------------------
module single_button_code_lock
#(
    parameter int DIGIT_COUNT = sbcl_pkg::DIGIT_COUNT_DEF,
    parameter int DIGIT_BITS  = sbcl_pkg::DIGIT_BITS_DEF,
    parameter int TIMER_BITS  = sbcl_pkg::TIMER_BITS_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [sbcl_pkg::IN_TDATA_BITS-1:0]   s_tdata,   // [0] key_event
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [1:0] lock_phase, [3:2] digits_entered, [7:4] press_total,
    // [8] digit_done, [9] verdict_valid, [10] code_matches
    output logic [sbcl_pkg::OUT_TDATA_BITS-1:0]  m_tdata,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [sbcl_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [sbcl_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    sbcl_pkg::cfg_t    cfg;
    sbcl_pkg::result_t result;
    logic              step;
    logic              key_event;
    logic              out_free;

    // configuration registers
    sbcl_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // input register
    sbcl_in_stage u_in
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .out_free  (out_free),
        .step      (step),
        .key_event (key_event)
    );

    // lock state and tick update
    sbcl_core
    #(
        .DIGIT_COUNT (DIGIT_COUNT),
        .DIGIT_BITS  (DIGIT_BITS),
        .TIMER_BITS  (TIMER_BITS)
    )
    u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .key_event (key_event),
        .cfg       (cfg),
        .result    (result)
    );

    // result register
    sbcl_out_stage u_out
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .result   (result),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
